@@ design/pds_pkg.sv @@
// Shared types and constants for the pawl disengage sequencer.
// No dependencies; imported by pawl_disengage_sequencer_unit.
package pds_pkg;

  // Item kinds on the input stream (carried in s_tuser).
  localparam logic [1:0] MODE_START      = 2'd0;
  localparam logic [1:0] MODE_MOTOR_DONE = 2'd1;
  localparam logic [1:0] MODE_READING    = 2'd2;

  // Start directions, also used as the active side code.
  localparam logic [1:0] SIDE_LEFT  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_REST  = 2'd2;
  localparam logic [1:0] SIDE_NONE  = 2'd3;

  // Sensor select codes.
  localparam logic [1:0] SENSE_LEFT  = 2'd0;
  localparam logic [1:0] SENSE_CAM   = 2'd1;
  localparam logic [1:0] SENSE_RIGHT = 2'd2;

  // Completion status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_FIRST_FAIL  = 3'd1;
  localparam logic [2:0] ST_ALREADY     = 3'd2;
  localparam logic [2:0] ST_PULSE_LIMIT = 3'd3;
  localparam logic [2:0] ST_READ_LIMIT  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEFT_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_RIGHT_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_CAM_LOWER       = 3'd2;
  localparam logic [2:0] REG_CAM_UPPER       = 3'd3;
  localparam logic [2:0] REG_CAM_OFFSET      = 3'd4;
  localparam logic [2:0] REG_TRY_LIMIT       = 3'd5;

  // Reset values and fixed pulse timing.
  localparam logic signed [16:0] CAM_LOWER_RESET  = -17'sd100;
  localparam logic signed [16:0] CAM_UPPER_RESET  = 17'sd100;
  localparam logic [15:0]        CAM_OFFSET_RESET = 16'd14781;
  localparam logic [7:0]         TRY_LIMIT_RESET  = 8'd10;
  localparam logic [6:0]         PULSE_TIME_INIT  = 7'd50;
  localparam logic [6:0]         PULSE_TIME_STEP  = 7'd5;
  localparam logic [6:0]         SIDE_PULSE_TIME  = 7'd100;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_FIRST = 4'b0010,
    PH_MOTOR = 4'b0100,
    PH_READ  = 4'b1000
  } phase_t;

  // One result item, last field in the lowest bits.
  typedef struct packed {
    logic [2:0] status;
    logic       finished;
    logic [1:0] sensor_select;
    logic       sensor_request;
    logic [6:0] motor_time;
    logic       motor_speed;
    logic       motor_forward;
    logic       motor_start;
  } result_t;

endpackage

@@ design/pawl_disengage_sequencer_unit.sv @@
// Top level of the pawl disengage sequencer: event decode, state update and
// a two-deep output buffer. Depends on pds_pkg.

// Pawl disengage sequencer. Every accepted input item (start command, motor
// finished event or sensor reading, kind in s_tuser) produces exactly one
// result item, all zero when the event causes no action. The block takes one
// item per clock while s_tready is high: the decision is a single pass of
// compare-and-count logic between the sequencer state registers and the
// output register, which holds the result for the master side. A skid
// register behind the output register keeps s_tready high for one more item
// while a result waits; s_tready drops only when both hold a result.
// Configuration writes are taken in any cycle (cfg_ready is always high);
// write them only while no sequence is running. Writes to indexes beyond the
// register list are dropped.
module pawl_disengage_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // direction[1:0], sensor_valid[2], sensor_value[18:3]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // motor_start[0], motor_forward[1], motor_speed[2],
                                 // motor_time[9:3], sensor_request[10],
                                 // sensor_select[12:11], finished[13], status[16:14]
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import pds_pkg::*;

  // Configuration registers.
  logic [15:0]        left_threshold;
  logic [15:0]        right_threshold;
  logic signed [16:0] cam_lower;
  logic signed [16:0] cam_upper;
  logic [15:0]        cam_offset;
  logic [7:0]         try_limit;

  // Sequencer state.
  phase_t     phase, phase_next;
  logic [1:0] active_side, active_side_next;
  logic [7:0] pulse_count, pulse_count_next;
  logic [7:0] read_count, read_count_next;
  logic [6:0] pulse_time, pulse_time_next;

  // Output buffer.
  result_t out_q, skid_q, res;
  logic    out_valid, skid_valid;

  // Input fields.
  logic [1:0]  in_mode;
  logic [1:0]  in_dir;
  logic        in_valid;
  logic [15:0] in_value;

  logic accept, take;

  logic               do_judge, first;
  logic signed [16:0] cam;
  logic               in_win, cam_pos;
  logic [15:0]        thr;
  logic [1:0]         side_sel;

  assign in_mode  = s_tuser;
  assign in_dir   = s_tdata[1:0];
  assign in_valid = s_tdata[2];
  assign in_value = s_tdata[18:3];

  assign s_tready  = ~skid_valid;
  assign accept    = s_tvalid & s_tready;
  assign take      = m_tvalid & m_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'd0, out_q};
  assign cfg_ready = 1'b1;

  // Window and threshold checks against the current reading.
  assign cam     = $signed({1'b0, in_value}) - $signed({1'b0, cam_offset});
  assign in_win  = (cam >= cam_lower) && (cam <= cam_upper);
  assign cam_pos = ~cam[16] && (cam != 17'sd0);
  assign thr     = (active_side == SIDE_LEFT) ? left_threshold : right_threshold;

  always_comb begin
    case (active_side)
      SIDE_LEFT:  side_sel = SENSE_LEFT;
      SIDE_RIGHT: side_sel = SENSE_RIGHT;
      default:    side_sel = SENSE_CAM;
    endcase
  end

  // Decide the result and next state for one item.
  always_comb begin
    res              = '0;
    phase_next       = phase;
    active_side_next = active_side;
    pulse_count_next = pulse_count;
    read_count_next  = read_count;
    pulse_time_next  = pulse_time;
    do_judge         = 1'b0;
    first            = 1'b0;

    case (in_mode)
      MODE_START: begin
        pulse_count_next = '0;
        read_count_next  = '0;
        pulse_time_next  = PULSE_TIME_INIT;
        if (in_dir == SIDE_NONE) begin
          active_side_next = SIDE_LEFT;
          res.finished     = 1'b1;
          res.status       = ST_OK;
          phase_next       = PH_IDLE;
        end else begin
          active_side_next = in_dir;
          res.sensor_request = 1'b1;
          case (in_dir)
            SIDE_LEFT:  res.sensor_select = SENSE_LEFT;
            SIDE_RIGHT: res.sensor_select = SENSE_RIGHT;
            default:    res.sensor_select = SENSE_CAM;
          endcase
          phase_next = PH_FIRST;
        end
      end
      MODE_MOTOR_DONE: begin
        if (phase == PH_MOTOR) begin
          res.sensor_request = 1'b1;
          res.sensor_select  = side_sel;
          phase_next         = PH_READ;
        end
      end
      MODE_READING: begin
        if (phase == PH_FIRST) begin
          if (!in_valid) begin
            res.finished = 1'b1;
            res.status   = ST_FIRST_FAIL;
            phase_next   = PH_IDLE;
          end else begin
            do_judge = 1'b1;
            first    = 1'b1;
          end
        end else if (phase == PH_READ) begin
          if (read_count >= try_limit) begin
            res.finished = 1'b1;
            res.status   = ST_READ_LIMIT;
            phase_next   = PH_IDLE;
          end else if (!in_valid) begin
            // Count the failed attempt and ask again.
            read_count_next    = read_count + 8'd1;
            res.sensor_request = 1'b1;
            res.sensor_select  = side_sel;
            phase_next         = PH_READ;
          end else begin
            read_count_next = '0;
            do_judge        = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_judge) begin
      if (active_side == SIDE_REST) begin
        if (first) begin
          if (in_win) begin
            res.finished = 1'b1;
            res.status   = ST_ALREADY;
            phase_next   = PH_IDLE;
          end else begin
            res.motor_start   = 1'b1;
            res.motor_forward = ~cam_pos;
            res.motor_speed   = 1'b0;
            res.motor_time    = pulse_time;
            phase_next        = PH_MOTOR;
          end
        end else if (pulse_count >= try_limit) begin
          res.finished = 1'b1;
          res.status   = ST_PULSE_LIMIT;
          phase_next   = PH_IDLE;
        end else begin
          // Advance the count and shorten the next pulse, saturating at zero.
          pulse_count_next = pulse_count + 8'd1;
          pulse_time_next  = (pulse_time >= PULSE_TIME_STEP) ?
                             pulse_time - PULSE_TIME_STEP : 7'd0;
          if (in_win) begin
            res.finished = 1'b1;
            res.status   = ST_OK;
            phase_next   = PH_IDLE;
          end else begin
            res.motor_start   = 1'b1;
            res.motor_forward = ~cam_pos;
            res.motor_speed   = 1'b0;
            res.motor_time    = pulse_time_next;
            phase_next        = PH_MOTOR;
          end
        end
      end else begin
        if (in_value <= thr) begin
          res.finished = 1'b1;
          res.status   = first ? ST_ALREADY : ST_OK;
          phase_next   = PH_IDLE;
        end else if (pulse_count >= try_limit) begin
          res.finished = 1'b1;
          res.status   = ST_PULSE_LIMIT;
          phase_next   = PH_IDLE;
        end else begin
          pulse_count_next  = pulse_count + 8'd1;
          res.motor_start   = 1'b1;
          res.motor_forward = (active_side == SIDE_RIGHT);
          res.motor_speed   = 1'b1;
          res.motor_time    = SIDE_PULSE_TIME;
          phase_next        = PH_MOTOR;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_threshold  <= '0;
      right_threshold <= '0;
      cam_lower       <= CAM_LOWER_RESET;
      cam_upper       <= CAM_UPPER_RESET;
      cam_offset      <= CAM_OFFSET_RESET;
      try_limit       <= TRY_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEFT_THRESHOLD:  left_threshold  <= cfg_data[15:0];
        REG_RIGHT_THRESHOLD: right_threshold <= cfg_data[15:0];
        REG_CAM_LOWER:       cam_lower       <= $signed(cfg_data);
        REG_CAM_UPPER:       cam_upper       <= $signed(cfg_data);
        REG_CAM_OFFSET:      cam_offset      <= cfg_data[15:0];
        REG_TRY_LIMIT:       try_limit       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state: advance on every accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      active_side <= SIDE_LEFT;
      pulse_count <= '0;
      read_count  <= '0;
      pulse_time  <= PULSE_TIME_INIT;
    end else if (accept) begin
      phase       <= phase_next;
      active_side <= active_side_next;
      pulse_count <= pulse_count_next;
      read_count  <= read_count_next;
      pulse_time  <= pulse_time_next;
    end
  end

  // Output register and skid register: drain the skid first to keep order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  // Skid stage only ever holds an item behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while output register is empty");

  // A finishing result never also drives the motor or asks for a reading.
  a_finish_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.finished) |-> (!out_q.motor_start && !out_q.sensor_request))
    else $error("finished result also starts motor or requests a reading");

  // A finished sequence leaves the sequencer idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && res.finished) |=> (phase == PH_IDLE))
    else $error("sequence finished but phase is not idle");

  // A motor pulse always leaves the sequencer waiting on the motor.
  a_pulse_waits: assert property (@(posedge clk) disable iff (rst)
    (accept && res.motor_start) |=> (phase == PH_MOTOR))
    else $error("motor pulse issued without entering motor wait");

  // A result waiting with no room downstream keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> (out_valid && $stable(out_q)))
    else $error("stalled result changed");

endmodule

@@ bench/pds_result_checker.sv @@
// Result checker for the pawl disengage sequencer: tracks register writes,
// predicts one command item per accepted event and compares the result stream.
// Depends on pds_pkg for codes, phase encoding and the result layout.
`timescale 1ns / 100ps

module pds_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // direction[1:0], sensor_valid[2], sensor_value[18:3]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // motor_start[0], motor_forward[1], motor_speed[2],
                                 // motor_time[9:3], sensor_request[10],
                                 // sensor_select[12:11], finished[13], status[16:14]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          err_count,
  output int          pending,
  output int          n_checked,
  output int          n_finished,
  output int          n_pulses
);
  import pds_pkg::*;

  localparam logic SPEED_SLOW   = 1'b0;
  localparam logic SPEED_MEDIUM = 1'b1;
  localparam logic DIR_BACKWARD = 1'b0;
  localparam logic DIR_FORWARD  = 1'b1;

  // register copies
  logic [15:0] thr_left, thr_right, cam_off;
  int          win_lo, win_hi;
  logic [7:0]  try_max;

  // sequencer state
  phase_t      phase;
  logic [1:0]  side;
  logic [7:0]  pulses, reads;
  logic [6:0]  ptime;

  result_t     cmd;
  result_t     due_cmds[$];
  int          errs, checked, done_cnt, pulse_cnt;

  task automatic end_seq(input logic [2:0] st);
    cmd.finished = 1'b1;
    cmd.status   = st;
    phase        = PH_IDLE;
  endtask

  task automatic ask_reading(input phase_t next);
    cmd.sensor_request = 1'b1;
    cmd.sensor_select  = (side == SIDE_LEFT)  ? SENSE_LEFT :
                         (side == SIDE_RIGHT) ? SENSE_RIGHT : SENSE_CAM;
    phase              = next;
  endtask

  task automatic rest_pulse(input int cam);
    cmd.motor_start   = 1'b1;
    cmd.motor_forward = (cam > 0) ? DIR_BACKWARD : DIR_FORWARD;
    cmd.motor_speed   = SPEED_SLOW;
    cmd.motor_time    = ptime;
    phase             = PH_MOTOR;
  endtask

  // Decide on a valid reading: the first one after a start, or one after a pulse.
  task automatic judge(input logic [15:0] val, input bit first);
    int          cam;
    bit          in_win;
    logic [15:0] thr;
    if (side == SIDE_REST) begin
      cam    = int'(val) - int'(cam_off);
      in_win = (cam >= win_lo) && (cam <= win_hi);
      if (first) begin
        if (in_win) end_seq(ST_ALREADY);
        else rest_pulse(cam);
      end else if (pulses >= try_max) begin
        end_seq(ST_PULSE_LIMIT);
      end else begin
        pulses = pulses + 8'd1;
        ptime  = (ptime >= PULSE_TIME_STEP) ? ptime - PULSE_TIME_STEP : 7'd0;
        if (in_win) end_seq(ST_OK);
        else rest_pulse(cam);
      end
    end else begin
      thr = (side == SIDE_LEFT) ? thr_left : thr_right;
      if (val <= thr) begin
        end_seq(first ? ST_ALREADY : ST_OK);
      end else if (pulses >= try_max) begin
        end_seq(ST_PULSE_LIMIT);
      end else begin
        pulses            = pulses + 8'd1;
        cmd.motor_start   = 1'b1;
        cmd.motor_forward = (side == SIDE_RIGHT) ? DIR_FORWARD : DIR_BACKWARD;
        cmd.motor_speed   = SPEED_MEDIUM;
        cmd.motor_time    = SIDE_PULSE_TIME;
        phase             = PH_MOTOR;
      end
    end
  endtask

  // Advance the sequencer by one event and leave its command in cmd.
  task automatic sequence_step(input logic [1:0] kind, input logic [1:0] dir,
                               input logic ok, input logic [15:0] val);
    cmd = '0;
    case (kind)
      MODE_START: begin
        pulses = '0;
        reads  = '0;
        ptime  = PULSE_TIME_INIT;
        if (dir == SIDE_NONE) begin
          side = SIDE_LEFT;
          end_seq(ST_OK);
        end else begin
          side = dir;
          ask_reading(PH_FIRST);
        end
      end
      MODE_MOTOR_DONE: begin
        if (phase == PH_MOTOR) ask_reading(PH_READ);
      end
      MODE_READING: begin
        if (phase == PH_FIRST) begin
          if (!ok) end_seq(ST_FIRST_FAIL);
          else judge(val, 1'b1);
        end else if (phase == PH_READ) begin
          if (reads >= try_max) begin
            end_seq(ST_READ_LIMIT);
          end else begin
            reads = reads + 8'd1;
            if (!ok) begin
              ask_reading(PH_READ);
            end else begin
              reads = '0;
              judge(val, 1'b0);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      thr_left  = '0;
      thr_right = '0;
      win_lo    = int'(CAM_LOWER_RESET);
      win_hi    = int'(CAM_UPPER_RESET);
      cam_off   = CAM_OFFSET_RESET;
      try_max   = TRY_LIMIT_RESET;
      phase     = PH_IDLE;
      side      = SIDE_LEFT;
      pulses    = '0;
      reads     = '0;
      ptime     = PULSE_TIME_INIT;
      due_cmds.delete();
      errs      = 0;
      checked   = 0;
      done_cnt  = 0;
      pulse_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT_THRESHOLD:  thr_left  = cfg_data[15:0];
          REG_RIGHT_THRESHOLD: thr_right = cfg_data[15:0];
          REG_CAM_LOWER:       win_lo    = int'($signed(cfg_data));
          REG_CAM_UPPER:       win_hi    = int'($signed(cfg_data));
          REG_CAM_OFFSET:      cam_off   = cfg_data[15:0];
          REG_TRY_LIMIT:       try_max   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(result_t)-1:0];
        if (due_cmds.size() == 0) begin
          $error("result item with nothing expected: tdata %h", m_tdata);
          errs++;
        end else begin
          want = due_cmds.pop_front();
          check_field("motor_start", int'(want.motor_start), int'(got.motor_start));
          check_field("motor_forward", int'(want.motor_forward), int'(got.motor_forward));
          check_field("motor_speed", int'(want.motor_speed), int'(got.motor_speed));
          check_field("motor_time", int'(want.motor_time), int'(got.motor_time));
          check_field("sensor_request", int'(want.sensor_request),
                      int'(got.sensor_request));
          check_field("sensor_select", int'(want.sensor_select), int'(got.sensor_select));
          check_field("finished", int'(want.finished), int'(got.finished));
          check_field("status", int'(want.status), int'(got.status));
          checked++;
          if (want.finished) done_cnt++;
          if (want.motor_start) pulse_cnt++;
        end
      end
      if (s_tvalid && s_tready) begin
        sequence_step(s_tuser, s_tdata[1:0], s_tdata[2], s_tdata[18:3]);
        due_cmds.push_back(cmd);
      end
    end
    err_count  <= errs;
    pending    <= due_cmds.size();
    n_checked  <= checked;
    n_finished <= done_cnt;
    n_pulses   <= pulse_cnt;
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the pawl disengage sequencer bench: clock, reset, event stimulus,
// register writes and verdict. Depends on pds_pkg and pds_result_checker.
`timescale 1ns / 100ps

module tb_top;
  import pds_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;  // no event kind; must be ignored
  localparam logic [2:0] REG_UNUSED  = 3'd6;  // beyond the register list
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 65;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 8;
  localparam int LIMIT       = 200000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // direction[1:0], sensor_valid[2], sensor_value[18:3]
  logic [1:0]  s_tuser;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // motor_start[0], motor_forward[1], motor_speed[2],
                          // motor_time[9:3], sensor_request[10],
                          // sensor_select[12:11], finished[13], status[16:14]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  int err_count, pending, n_checked, n_finished, n_pulses;

  // Idle percentages, changed per phase by the stimulus process.
  int s_idle = 0;
  int r_stall = 0;
  // Hold-off request for the receiver: bump hold_req to start one.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int n_sent = 0;
  int n_settings = 0;
  int cycle_cnt = 0;

  // Copies of the register values last written, used to aim sensor values.
  int cur_left = 0;
  int cur_right = 0;
  int cur_lo = -100;
  int cur_hi = 100;
  int cur_off = 14781;
  int cur_lim = 10;

  pawl_disengage_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pds_result_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .err_count  (err_count),
    .pending    (pending),
    .n_checked  (n_checked),
    .n_finished (n_finished),
    .n_pulses   (n_pulses)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: stall at random, or hold off completely for a long stretch
  // when asked, so the output buffer fills and the block stalls its input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= r_stall);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("** pawl_disengage_sequencer_unit: FAILED **");
      $finish;
    end
  end

  // Offer one event item, after a random gap, and hold it until accepted.
  // Leave tvalid high afterwards; a gap in the next call or a drain lowers it.
  task automatic send_item(input logic [1:0] kind, input logic [1:0] dir,
                           input logic ok, input logic [15:0] val);
    while ($urandom_range(99) < s_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, val, ok, dir};
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  // Drop tvalid and wait until every expected result has come back, then
  // let the pipeline settle before touching the registers.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Write one register; cfg_valid stays high for back-to-back writes.
  task automatic cfg_write(input logic [2:0] idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the whole register set while the block is idle.
  task automatic cfg_set(input int left, input int right, input int lo,
                         input int hi, input int off, input int lim);
    cfg_write(REG_LEFT_THRESHOLD, left[16:0]);
    cfg_write(REG_RIGHT_THRESHOLD, right[16:0]);
    cfg_write(REG_CAM_LOWER, lo[16:0]);
    cfg_write(REG_CAM_UPPER, hi[16:0]);
    cfg_write(REG_CAM_OFFSET, off[16:0]);
    cfg_write(REG_TRY_LIMIT, lim[16:0]);
    cfg_valid <= 1'b0;
    cur_left  = left;
    cur_right = right;
    cur_lo    = lo;
    cur_hi    = hi;
    cur_off   = off;
    cur_lim   = lim;
    n_settings++;
  endtask

  // Aim a sensor value at the decision boundary for the given side: inside
  // the window or at/below the threshold, just outside it, or anywhere.
  function automatic logic [15:0] pick_value(input logic [1:0] dir);
    int v, thr;
    if (dir == SIDE_REST) begin
      case ($urandom_range(3))
        0: v = $urandom_range(65535);
        1: v = cur_off + cur_lo + int'($urandom_range(cur_hi - cur_lo));
        2: v = cur_off + cur_lo - 1 - int'($urandom_range(50));
        default: v = cur_off + cur_hi + 1 + int'($urandom_range(50));
      endcase
    end else begin
      thr = (dir == SIDE_LEFT) ? cur_left : cur_right;
      case ($urandom_range(3))
        0: v = $urandom_range(65535);
        1: v = thr - int'($urandom_range(20));
        default: v = thr + 1 + int'($urandom_range(20));
      endcase
    end
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // One well-formed disengage sequence with random content: start, first
  // reading, then rounds of motor-done and readings, some transfers failing.
  task automatic run_sequence();
    logic [1:0] dir;
    int steps, fails, cap;
    dir   = 2'($urandom_range(2));
    steps = $urandom_range((cur_lim < 11) ? cur_lim + 2 : 12);
    cap   = (cur_lim < 11) ? cur_lim + 1 : 12;
    send_item(MODE_START, dir, 1'($urandom), 16'($urandom));
    send_item(MODE_READING, 2'($urandom), ($urandom_range(19) != 0), pick_value(dir));
    repeat (steps) begin
      send_item(MODE_MOTOR_DONE, 2'($urandom), 1'($urandom), 16'($urandom));
      fails = ($urandom_range(4) == 0) ? $urandom_range(cap) : 0;
      repeat (fails) send_item(MODE_READING, 2'($urandom), 1'b0, 16'($urandom));
      send_item(MODE_READING, 2'($urandom), 1'b1, pick_value(dir));
    end
  endtask

  initial begin
    int ph, target;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = MODE_START;
    cfg_valid = 1'b0;
    cfg_index = REG_LEFT_THRESHOLD;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset register values.
    // Events while idle, and the unused kind, must all be ignored.
    send_item(MODE_READING, SIDE_LEFT, 1'b1, 16'hFFFF);
    send_item(MODE_MOTOR_DONE, SIDE_LEFT, 1'b0, 16'h0000);
    send_item(MODE_UNUSED, SIDE_NONE, 1'b1, 16'hFFFF);
    // Unknown direction ends at once.
    send_item(MODE_START, SIDE_NONE, 1'b0, 16'h0000);
    // First read fails; left pawl already disengaged.
    send_item(MODE_START, SIDE_LEFT, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_LEFT, 1'b0, 16'h1234);
    send_item(MODE_START, SIDE_LEFT, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_LEFT, 1'b1, 16'h0000);
    // Right side: pulse, failed re-read, then disengaged.
    send_item(MODE_START, SIDE_RIGHT, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_RIGHT, 1'b1, 16'hFFFF);
    send_item(MODE_MOTOR_DONE, SIDE_RIGHT, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_RIGHT, 1'b0, 16'hFFFF);
    send_item(MODE_READING, SIDE_RIGHT, 1'b1, 16'h0000);
    // Rest: centred on the first read.
    send_item(MODE_START, SIDE_REST, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_REST, 1'b1, CAM_OFFSET_RESET);
    // Rest: forward pulse, restart while busy, backward pulses, shrinking time.
    send_item(MODE_START, SIDE_REST, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_REST, 1'b1, 16'h0000);
    send_item(MODE_START, SIDE_REST, 1'b1, 16'hFFFF);
    send_item(MODE_READING, SIDE_REST, 1'b1, 16'hFFFF);
    send_item(MODE_MOTOR_DONE, SIDE_REST, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_REST, 1'b1, 16'hFFFF);
    send_item(MODE_MOTOR_DONE, SIDE_REST, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_REST, 1'b1, CAM_OFFSET_RESET);
    drain();

    // Zero try limit: first side pulse hits the pulse limit, and the first
    // counted read in rest mode hits the read limit. The write beyond the
    // register list must be dropped.
    cfg_write(REG_TRY_LIMIT, 17'd0);
    cfg_write(REG_UNUSED, 17'($urandom));
    cfg_valid <= 1'b0;
    cur_lim = 0;
    send_item(MODE_START, SIDE_LEFT, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_LEFT, 1'b1, 16'hFFFF);
    send_item(MODE_START, SIDE_REST, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_REST, 1'b1, 16'h0000);
    send_item(MODE_MOTOR_DONE, SIDE_REST, 1'b0, 16'h0000);
    send_item(MODE_READING, SIDE_REST, 1'b1, CAM_OFFSET_RESET);
    drain();

    // Random part: one register setting and one idle pattern per phase.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: cfg_set(0, 0, -100, 100, 14781, 10);
        1: cfg_set(65535, 65535, -65536, 65535, 0, 255);
        2: cfg_set(1000, 30000, -50, 50, 65535, 3);
        3: cfg_set(32768, 12, -3, 3, 32768, 1);
        5: cfg_set(500, 500, 0, 0, 100, 2);
        7: cfg_set(65535, 0, 65535, 65535, 0, 5);
        default: cfg_set($urandom_range(65535), $urandom_range(65535),
                         -int'($urandom_range(200)), $urandom_range(200),
                         $urandom_range(65535), $urandom_range(1, 6));
      endcase
      case (ph % 4)
        0: begin s_idle = 0;  r_stall = 0;  end
        1: begin s_idle = 83; r_stall = 0;  end
        2: begin s_idle = 0;  r_stall = 83; end
        default: begin s_idle = 34; r_stall = 34; end
      endcase
      // Hold the receiver off while the sender keeps offering at full rate.
      if (ph == 2) hold_req++;
      target = n_sent + PHASE_ITEMS;
      while (n_sent < target) begin
        if ($urandom_range(99) < 15)
          send_item(2'($urandom), 2'($urandom), 1'($urandom), 16'($urandom));
        else
          run_sequence();
      end
      drain();
    end

    $display("Sent %0d event items over %0d register settings: %0d results checked,",
             n_sent, n_settings, n_checked);
    $display("%0d sequences ended and %0d motor pulses commanded.", n_finished, n_pulses);
    if (err_count == 0 && pending == 0)
      $display("** pawl_disengage_sequencer_unit: PASSED **");
    else
      $display("** pawl_disengage_sequencer_unit: FAILED **");
    $finish;
  end

endmodule
